// ===== hw/rtl/slsg3d_pkg.sv =====
// ----------------------------------------------------------------------------
// slsg3d_pkg
// Types, codes and helpers shared by the three-axis line step generator.
// ----------------------------------------------------------------------------
package slsg3d_pkg;

	localparam int COORD_BITS = 20;
	localparam int DIFF_BITS  = COORD_BITS + 2;
	localparam int ABS_BITS   = COORD_BITS + 1;
	localparam int TAD_BITS   = COORD_BITS + 2;
	localparam int ERR_BITS   = COORD_BITS + 3;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	localparam logic [2:0][5:0] MOVE_NEG = {6'd48, 6'd4, 6'd1};
	localparam logic [2:0][5:0] MOVE_POS = {6'd16, 6'd12, 6'd3};
	localparam logic [2:0][5:0] HOLD_NEG = {6'd32, 6'd0, 6'd0};
	localparam logic [2:0][5:0] HOLD_POS = {6'd0, 6'd8, 6'd2};

	typedef struct packed {
		logic                          func;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] start_z;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic signed [COORD_BITS-1:0] end_z;
	} req_t;

	typedef struct packed {
		logic [5:0]                    move_code;
		logic [5:0]                    hold_code;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic                          last;
	} rsp_t;

	typedef struct packed {
		logic                           active;
		logic [2:0][COORD_BITS-1:0]     pos;
		axis_t                          lead;
		logic [2:0]                     neg;
		logic [2:0][TAD_BITS-1:0]       tad;
		logic [1:0][ERR_BITS-1:0]       err;
		logic [ABS_BITS-1:0]            steps_left;
	} mv_state_t;

	function automatic axis_t minor_axis(axis_t lead, logic slot);
		axis_t m;
		case (lead)
			AXIS_Y:  m = slot ? AXIS_Z : AXIS_X;
			AXIS_Z:  m = slot ? AXIS_X : AXIS_Y;
			default: m = slot ? AXIS_Z : AXIS_Y;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/slsg3d_setup.sv =====
// ----------------------------------------------------------------------------
// slsg3d_setup
// Forms deltas, lead axis, error terms and step count for a start item.
// ----------------------------------------------------------------------------
module slsg3d_setup (
	input  slsg3d_pkg::req_t      item,
	output slsg3d_pkg::mv_state_t nxt
);
	import slsg3d_pkg::*;

	logic [2:0][COORD_BITS-1:0] st;
	logic [2:0][COORD_BITS-1:0] en;
	logic [2:0][DIFF_BITS-1:0]  diff;
	logic [2:0][ABS_BITS-1:0]   absd;
	logic [2:0]                 neg;
	axis_t                      lead;
	axis_t                      m0;
	axis_t                      m1;

	assign st = {item.start_z, item.start_y, item.start_x};
	assign en = {item.end_z, item.end_y, item.end_x};

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = {{2{en[a][COORD_BITS-1]}}, en[a]} - {{2{st[a][COORD_BITS-1]}}, st[a]};
			neg[a]  = diff[a][DIFF_BITS-1];
			absd[a] = neg[a] ? ABS_BITS'(~diff[a] + 1'b1) : diff[a][ABS_BITS-1:0];
		end
	end

	always_comb begin
		if (absd[0] >= absd[1] && absd[0] >= absd[2]) begin
			lead = AXIS_X;
		end else if (absd[1] >= absd[2]) begin
			lead = AXIS_Y;
		end else begin
			lead = AXIS_Z;
		end
	end

	assign m0 = minor_axis(lead, 1'b0);
	assign m1 = minor_axis(lead, 1'b1);

	always_comb begin
		nxt.pos  = st;
		nxt.lead = lead;
		nxt.neg  = neg;
		for (int a = 0; a < 3; a++) begin
			nxt.tad[a] = {absd[a], 1'b0};
		end
		nxt.err[0]     = {1'b0, absd[m0], 1'b0} - {2'b00, absd[lead]};
		nxt.err[1]     = {1'b0, absd[m1], 1'b0} - {2'b00, absd[lead]};
		nxt.steps_left = absd[lead];
		nxt.active     = (absd[lead] != '0);
	end

endmodule

// ===== hw/rtl/slsg3d_step.sv =====
// ----------------------------------------------------------------------------
// slsg3d_step
// Takes one Bresenham step from the current move state.
// ----------------------------------------------------------------------------
module slsg3d_step (
	input  slsg3d_pkg::mv_state_t cur,
	output slsg3d_pkg::mv_state_t nxt,
	output slsg3d_pkg::rsp_t      res
);
	import slsg3d_pkg::*;

	axis_t                   m [2];
	logic [1:0]              fire;
	logic [2:0]              stp;
	logic [ERR_BITS:0]       e [2];
	logic [5:0]              mv;
	logic [5:0]              hd;

	assign m[0] = minor_axis(cur.lead, 1'b0);
	assign m[1] = minor_axis(cur.lead, 1'b1);

	always_comb begin
		stp = '0;
		for (int k = 0; k < 2; k++) begin
			fire[k] = !cur.err[k][ERR_BITS-1] && (cur.err[k] != '0);
			if (fire[k]) begin
				stp[m[k]] = 1'b1;
			end
		end
		stp[cur.lead] = 1'b1;
	end

	always_comb begin
		nxt = cur;
		for (int k = 0; k < 2; k++) begin
			e[k] = {cur.err[k][ERR_BITS-1], cur.err[k]};
			if (fire[k]) begin
				e[k] = e[k] - {2'b00, cur.tad[cur.lead]};
			end
			e[k] = e[k] + {2'b00, cur.tad[m[k]]};
			nxt.err[k] = e[k][ERR_BITS-1:0];
		end
		mv = '0;
		hd = '0;
		for (int a = 0; a < 3; a++) begin
			if (stp[a]) begin
				if (cur.neg[a]) begin
					nxt.pos[a] = cur.pos[a] - 1'b1;
					mv = mv | MOVE_NEG[a];
					hd = hd | HOLD_NEG[a];
				end else begin
					nxt.pos[a] = cur.pos[a] + 1'b1;
					mv = mv | MOVE_POS[a];
					hd = hd | HOLD_POS[a];
				end
			end
		end
		nxt.steps_left = cur.steps_left - 1'b1;
		nxt.active     = (cur.steps_left != ABS_BITS'(1));
	end

	always_comb begin
		res.move_code = mv;
		res.hold_code = hd;
		res.pos_x     = nxt.pos[0];
		res.pos_y     = nxt.pos[1];
		res.pos_z     = nxt.pos[2];
		res.last      = (cur.steps_left == ABS_BITS'(1));
	end

endmodule

// ===== hw/rtl/stepper_line_step_generator_3d.sv =====
// Items are registered on entry, and tick step results in the result register.
// Throughput: one item per cycle without rsp_stall; start and tick items may
// follow back to back; the move state register gets setup or active step output.
// Reset: arst_n low clears the move state to idle at position zero and empties
// the input and result registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// stepper_line_step_generator_3d
// Three-axis line step generator: start items load a move, tick items step it.
// ----------------------------------------------------------------------------
module stepper_line_step_generator_3d (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  slsg3d_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output slsg3d_pkg::rsp_t rsp
);
	import slsg3d_pkg::*;

	logic      valid_s1;
	req_t      item_s1;
	mv_state_t state_q;
	mv_state_t setup_nxt;
	mv_state_t step_nxt;
	rsp_t      step_res;
	logic      rsp_valid_q;
	rsp_t      rsp_q;
	logic      produce;
	logic      adv;

	slsg3d_setup u_setup (
		.item (item_s1),
		.nxt  (setup_nxt)
	);

	slsg3d_step u_step (
		.cur (state_q),
		.nxt (step_nxt),
		.res (step_res)
	);

	assign produce   = (item_s1.func == FUNC_TICK) && state_q.active;
	assign adv       = valid_s1 && (!produce || !rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			if (item_s1.func == FUNC_START) begin
				state_q <= setup_nxt;
			end else if (state_q.active) begin
				state_q <= step_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv && produce) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			rsp_q <= step_res;
		end
	end

endmodule

// ===== bench/stepper_line_step_generator_3d_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_line_step_generator_3d_tb
// Drives start and tick items into the three-axis line step generator and
// checks every step against a cycle-free line predictor held in a scoreboard.
// ----------------------------------------------------------------------------
module stepper_line_step_generator_3d_tb;
	import slsg3d_pkg::*;

	localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;
	localparam int CMIN = -(1 << (COORD_BITS - 1));

	class step_tracker;
		rsp_t                          due_steps[$];
		int                            errors;
		bit                            moving;
		logic signed [COORD_BITS-1:0]  cur[3];
		axis_t                         lead;
		bit                            neg[3];
		longint                        twice_d[3];
		longint                        err_t[2];
		longint                        remaining;
		int                            minor_tbl[3][2] = '{'{1, 2}, '{0, 2}, '{1, 0}};

		task report(string msg);
			$display("%0t ns: step mismatch: %s", $time, msg);
			errors++;
		endtask

		function void step_axis(int a, inout logic [5:0] mv, inout logic [5:0] hd);
			if (neg[a]) begin
				cur[a] = cur[a] - 1'b1;
				mv |= MOVE_NEG[a];
				hd |= HOLD_NEG[a];
			end else begin
				cur[a] = cur[a] + 1'b1;
				mv |= MOVE_POS[a];
				hd |= HOLD_POS[a];
			end
		endfunction

		function void take_item(req_t r);
			longint     s[3];
			longint     e[3];
			longint     ad[3];
			int         ld;
			int         m;
			logic [5:0] mv;
			logic [5:0] hd;
			rsp_t       want;
			if (r.func == FUNC_START) begin
				s[0] = $signed(r.start_x);
				s[1] = $signed(r.start_y);
				s[2] = $signed(r.start_z);
				e[0] = $signed(r.end_x);
				e[1] = $signed(r.end_y);
				e[2] = $signed(r.end_z);
				for (int a = 0; a < 3; a++) begin
					cur[a] = s[a][COORD_BITS-1:0];
					neg[a] = (e[a] < s[a]);
					ad[a] = neg[a] ? s[a] - e[a] : e[a] - s[a];
					twice_d[a] = 2 * ad[a];
				end
				if (ad[0] >= ad[1] && ad[0] >= ad[2])
					lead = AXIS_X;
				else if (ad[1] >= ad[2])
					lead = AXIS_Y;
				else
					lead = AXIS_Z;
				ld = int'(lead);
				for (int k = 0; k < 2; k++)
					err_t[k] = twice_d[minor_tbl[ld][k]] - ad[ld];
				remaining = ad[ld];
				moving = (remaining != 0);
				return;
			end
			if (!moving)
				return;
			ld = int'(lead);
			mv = '0;
			hd = '0;
			for (int k = 0; k < 2; k++) begin
				m = minor_tbl[ld][k];
				if (err_t[k] > 0) begin
					step_axis(m, mv, hd);
					err_t[k] -= twice_d[ld];
				end
				err_t[k] += twice_d[m];
			end
			step_axis(ld, mv, hd);
			remaining--;
			if (remaining == 0)
				moving = 1'b0;
			want.move_code = mv;
			want.hold_code = hd;
			want.pos_x = cur[0];
			want.pos_y = cur[1];
			want.pos_z = cur[2];
			want.last = !moving;
			due_steps.push_back(want);
		endfunction

		task check_step(rsp_t got);
			rsp_t want;
			if (due_steps.size() == 0) begin
				report("result with no step due");
				return;
			end
			want = due_steps.pop_front();
			if (got.move_code !== want.move_code)
				report($sformatf("move_code got %0d want %0d", got.move_code, want.move_code));
			if (got.hold_code !== want.hold_code)
				report($sformatf("hold_code got %0d want %0d", got.hold_code, want.hold_code));
			if (got.pos_x !== want.pos_x)
				report($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
			if (got.pos_y !== want.pos_y)
				report($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
			if (got.pos_z !== want.pos_z)
				report($sformatf("pos_z got %0d want %0d", got.pos_z, want.pos_z));
			if (got.last !== want.last)
				report($sformatf("last got %0b want %0b", got.last, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int send_idle = 15;
	int recv_idle = 53;

	step_tracker track = new();

	stepper_line_step_generator_3d u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			rsp_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				track.take_item(req);
			if (rsp_valid && !rsp_stall)
				track.check_step(rsp);
		end
	end

	initial begin
		#20_000_000;
		$display("stepper_line_step_generator_3d_tb: errors");
		$finish;
	end

	function automatic req_t tick_item();
		req_t t;
		t.func = FUNC_TICK;
		t.start_x = COORD_BITS'($urandom());
		t.start_y = COORD_BITS'($urandom());
		t.start_z = COORD_BITS'($urandom());
		t.end_x = COORD_BITS'($urandom());
		t.end_y = COORD_BITS'($urandom());
		t.end_z = COORD_BITS'($urandom());
		return t;
	endfunction

	function automatic int rand_coord();
		int pick;
		pick = $urandom_range(99);
		if (pick < 3)
			return CMIN;
		if (pick < 6)
			return CMAX;
		return $urandom_range(0, (1 << COORD_BITS) - 1) + CMIN;
	endfunction

	task automatic push_item(input req_t r);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic push_move(input int sx, input int sy, input int sz,
			input int ex, input int ey, input int ez, input int n_ticks);
		req_t r;
		r.func = FUNC_START;
		r.start_x = COORD_BITS'(sx);
		r.start_y = COORD_BITS'(sy);
		r.start_z = COORD_BITS'(sz);
		r.end_x = COORD_BITS'(ex);
		r.end_y = COORD_BITS'(ey);
		r.end_z = COORD_BITS'(ez);
		push_item(r);
		repeat (n_ticks) push_item(tick_item());
	endtask

	task automatic run_random(input int target);
		int done;
		int pick;
		int span;
		int len;
		int n_ticks;
		int s[3];
		int d[3];
		int e[3];
		done = 0;
		while (done < target) begin
			pick = $urandom_range(99);
			if (pick < 82) begin
				pick = $urandom_range(99);
				span = (pick < 90) ? 9 : (pick < 98) ? 40 : 250;
				len = 0;
				for (int a = 0; a < 3; a++) begin
					s[a] = rand_coord();
					d[a] = $urandom_range(0, span);
					if ($urandom_range(1))
						d[a] = -d[a];
					if ($urandom_range(19) == 0)
						d[a] = 0;
				end
				if ($urandom_range(19) == 0)
					d = '{0, 0, 0};
				for (int a = 0; a < 3; a++) begin
					e[a] = s[a] + d[a];
					if (e[a] > CMAX || e[a] < CMIN)
						e[a] = s[a] - d[a];
					if (d[a] > len)
						len = d[a];
					if (-d[a] > len)
						len = -d[a];
				end
				if ($urandom_range(7) == 0)
					n_ticks = $urandom_range(0, len);
				else
					n_ticks = len + $urandom_range(0, 2);
				push_move(s[0], s[1], s[2], e[0], e[1], e[2], n_ticks);
				done += 1 + n_ticks;
			end else if (pick < 90) begin
				push_item(tick_item());
				done++;
			end else begin
				n_ticks = $urandom_range(0, 4);
				push_move(rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), n_ticks);
				done += 1 + n_ticks;
			end
		end
	endtask

	initial begin
		int waited;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(tick_item());
		push_move(5, -7, 9, 5, -7, 9, 1);
		push_move(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 2);
		push_move(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 2);
		push_move(10, 10, 10, 8, 8, 8, 2);
		push_move(0, 0, 0, 1, 3, -3, 3);
		push_move(-3, 4, 100, -4, 6, 96, 5);

		run_random(183);
		send_idle = 53;
		recv_idle = 15;
		run_random(183);
		send_idle = 0;
		recv_idle = 0;
		run_random(184);
		req_valid <= 1'b0;

		waited = 0;
		while (track.due_steps.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (track.due_steps.size() != 0)
			track.report($sformatf("%0d steps never arrived", track.due_steps.size()));
		if (track.errors == 0)
			$display("stepper_line_step_generator_3d_tb: clean");
		else
			$display("stepper_line_step_generator_3d_tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/slsg3d_pkg.sv
hw/rtl/slsg3d_setup.sv
hw/rtl/slsg3d_step.sv
hw/rtl/stepper_line_step_generator_3d.sv
bench/stepper_line_step_generator_3d_tb.sv
